// ===== src/sensor_scratchpad_checker_macros.svh =====
// Assertion macros shared by the scratchpad checker modules.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef SENSOR_SCRATCHPAD_CHECKER_MACROS_SVH
`define SENSOR_SCRATCHPAD_CHECKER_MACROS_SVH

// Implication within the same cycle.
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ssc_pkg.sv =====
`default_nettype none

package ssc_pkg;

    // Number of leading scratchpad bytes covered by the CRC (1 to 8).
    localparam int unsigned CRC_SPAN = 8;

    localparam logic [7:0] CRC_POLY_REFLECTED = 8'h8C;
    localparam logic [7:0] RES_FIELD_MASK     = 8'h60;
    localparam int unsigned RES_FIELD_SHIFT   = 5;

    localparam logic [3:0] POS_TEMP_LOW   = 4'd0;
    localparam logic [3:0] POS_TEMP_HIGH  = 4'd1;
    localparam logic [3:0] POS_ALARM_HIGH = 4'd2;
    localparam logic [3:0] POS_ALARM_LOW  = 4'd3;
    localparam logic [3:0] POS_CONFIG     = 4'd4;
    localparam logic [3:0] POS_LAST       = 4'd8;
    localparam logic [3:0] POS_IDLE       = 4'd9;

    // One decoded scratchpad frame.
    typedef struct packed {
        logic [15:0] temperature_sixteenths;
        logic [11:0] whole_degrees;
        logic [3:0]  fraction_sixteenths;
        logic [7:0]  high_alarm;
        logic [7:0]  low_alarm;
        logic [7:0]  config_byte;
        logic [1:0]  resolution_index;
        logic        crc_ok;
        logic [7:0]  computed_crc;
    } ssc_result_t;

endpackage

`default_nettype wire

// ===== src/ssc_frame.sv =====
`default_nettype none

`include "sensor_scratchpad_checker_macros.svh"

module ssc_frame
    import ssc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  byte_value,
    input  wire logic        frame_start,
    output logic             produce,
    output ssc_result_t      result
);

    logic [3:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] temp_low_reg, temp_low_next;
    logic [7:0] temp_high_reg, temp_high_next;
    logic [7:0] alarm_high_reg, alarm_high_next;
    logic [7:0] alarm_low_reg, alarm_low_next;
    logic [7:0] config_reg, config_next;

    logic [3:0]  eff_pos;
    logic [7:0]  crc_base;
    logic [7:0]  crc_byte;
    logic [15:0] raw;
    logic [1:0]  res;
    logic [3:0]  keep_mask;

    // Reflected CRC-8 over one byte, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    always_comb
    begin
        eff_pos  = frame_start ? POS_TEMP_LOW : pos_reg;
        crc_base = frame_start ? 8'h00 : crc_reg;
        crc_byte = crc8_byte(crc_base, byte_value);

        pos_next        = pos_reg;
        crc_next        = crc_reg;
        temp_low_next   = temp_low_reg;
        temp_high_next  = temp_high_reg;
        alarm_high_next = alarm_high_reg;
        alarm_low_next  = alarm_low_reg;
        config_next     = config_reg;
        produce         = 1'b0;

        if (accept && (eff_pos < POS_IDLE)) begin
            if (eff_pos < 4'(CRC_SPAN) && eff_pos < POS_LAST)
                crc_next = crc_byte;
            else
                crc_next = crc_base;

            case (eff_pos)
                POS_TEMP_LOW:   temp_low_next   = byte_value;
                POS_TEMP_HIGH:  temp_high_next  = byte_value;
                POS_ALARM_HIGH: alarm_high_next = byte_value;
                POS_ALARM_LOW:  alarm_low_next  = byte_value;
                POS_CONFIG:     config_next     = byte_value;
                default:        ;
            endcase

            if (eff_pos < POS_LAST) begin
                pos_next = eff_pos + 4'd1;
            end
            else begin
                pos_next = POS_IDLE;
                produce  = 1'b1;
            end
        end
        else if (accept) begin
            // A start byte always lands in the branch above, so only the idle
            // position reaches here and it is left as it is.
            pos_next = pos_reg;
        end
    end

    // Result decode from the stored bytes; only sampled on the last byte.
    always_comb
    begin
        raw = {temp_high_reg, temp_low_reg};
        res = 2'((config_reg & RES_FIELD_MASK) >> RES_FIELD_SHIFT);
        case (res)
            2'd0:    keep_mask = 4'b1000;
            2'd1:    keep_mask = 4'b1100;
            2'd2:    keep_mask = 4'b1110;
            default: keep_mask = 4'b1111;
        endcase

        result.temperature_sixteenths = {raw[15:4], raw[3:0] & keep_mask};
        result.whole_degrees          = raw[15:4];
        result.fraction_sixteenths    = raw[3:0] & keep_mask;
        result.high_alarm             = alarm_high_reg;
        result.low_alarm              = alarm_low_reg;
        result.config_byte            = config_reg;
        result.resolution_index       = res;
        result.crc_ok                 = (crc_reg == byte_value);
        result.computed_crc           = crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= POS_TEMP_LOW;
            crc_reg        <= 8'h00;
            temp_low_reg   <= 8'h00;
            temp_high_reg  <= 8'h00;
            alarm_high_reg <= 8'h00;
            alarm_low_reg  <= 8'h00;
            config_reg     <= 8'h00;
        end
        else begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            temp_low_reg   <= temp_low_next;
            temp_high_reg  <= temp_high_next;
            alarm_high_reg <= alarm_high_next;
            alarm_low_reg  <= alarm_low_next;
            config_reg     <= config_next;
        end
    end

    `SSC_ASSERT_NOW(a_pos_in_range, 1'b1, pos_reg <= POS_IDLE, "byte position out of range")
    `SSC_ASSERT_NEXT(a_idle_after_result, produce, pos_reg == POS_IDLE, "not idle after a frame")
    `SSC_ASSERT_NEXT(a_idle_holds, accept && !frame_start && pos_reg == POS_IDLE,
        pos_reg == POS_IDLE && !produce, "idle position left without a start byte")
    `SSC_ASSERT_NEXT(a_start_restarts, accept && frame_start,
        pos_reg == POS_TEMP_HIGH, "start byte did not restart the frame")

endmodule

`default_nettype wire

// ===== src/ssc_out_reg.sv =====
`default_nettype none

`include "sensor_scratchpad_checker_macros.svh"

module ssc_out_reg
    import ssc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire ssc_result_t  load_data,
    input  wire logic         result_ready,
    output logic              result_valid,
    output logic              space,
    output ssc_result_t       data
);

    logic        valid_reg, valid_next;
    ssc_result_t data_reg;

    // The register can take a new result when empty or emptying this cycle.
    assign space = !valid_reg || result_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign result_valid = valid_reg;
    assign data         = data_reg;

    `SSC_ASSERT_NOW(a_no_overwrite, load, !valid_reg || result_ready,
        "pending result overwritten")

endmodule

`default_nettype wire

// ===== src/sensor_scratchpad_checker.sv =====
// Scratchpad checker for a one-wire temperature sensor. Bytes of the 9-byte
// scratchpad arrive one per transfer on the byte channel, byte 0 first; a
// transfer with frame_start high is taken as byte 0 and restarts the frame and
// the CRC. The reflected CRC-8 (polynomial 0x8C, initial value zero) runs over
// the leading bytes and is compared with byte 8, and the transfer of byte 8
// yields one result transfer carrying the temperature in signed sixteenths of
// a degree (fraction bits below the resolution in config bits 6:5 cleared),
// the whole degrees, the alarm bytes, the config byte, the resolution index and
// the CRC verdict. Bytes after byte 8 without a new start are dropped without
// a result. The block takes one byte per clock cycle: the CRC step is a single
// byte-wide XOR network from the byte port into the CRC register, and the
// result register is loaded at the very edge that transfers byte 8, so the
// result is offered on the result channel from the next cycle on. The byte
// channel stalls only while a finished result waits in the output register and
// result_ready is low.

`default_nettype none

module sensor_scratchpad_checker
    import ssc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire logic [7:0]         byte_value,
    input  wire logic               frame_start,

    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [15:0]      temperature_sixteenths,
    output logic signed [11:0]      whole_degrees,
    output logic [3:0]              fraction_sixteenths,
    output logic signed [7:0]       high_alarm,
    output logic signed [7:0]       low_alarm,
    output logic [7:0]              config_byte,
    output logic [1:0]              resolution_index,
    output logic                    crc_ok,
    output logic [7:0]              computed_crc
);

    logic        accept;
    logic        produce;
    logic        space;
    ssc_result_t frame_result;
    ssc_result_t held_result;

    // A byte transfer completes whenever the output register has room.
    assign byte_ready = space;
    assign accept     = byte_valid && byte_ready;

    ssc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .byte_value  (byte_value),
        .frame_start (frame_start),
        .produce     (produce),
        .result      (frame_result)
    );

    ssc_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (produce),
        .load_data    (frame_result),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .space        (space),
        .data         (held_result)
    );

    // Unpack the held result onto the individual field ports.
    assign temperature_sixteenths = $signed(held_result.temperature_sixteenths);
    assign whole_degrees          = $signed(held_result.whole_degrees);
    assign fraction_sixteenths    = held_result.fraction_sixteenths;
    assign high_alarm             = $signed(held_result.high_alarm);
    assign low_alarm              = $signed(held_result.low_alarm);
    assign config_byte            = held_result.config_byte;
    assign resolution_index       = held_result.resolution_index;
    assign crc_ok                 = held_result.crc_ok;
    assign computed_crc           = held_result.computed_crc;

endmodule

`default_nettype wire

// ===== test/sensor_scratchpad_checker_tb.sv =====
module sensor_scratchpad_checker_tb;
    import ssc_pkg::*;

    // Bytes that change the decoder state before the random part stops.
    localparam int ITEM_TARGET = 1100;
    // The cycle budget covers every byte and every result waiting out the
    // longest gap on its side, the long hold on the result side, and then
    // several times that again.
    localparam int CYCLE_LIMIT = 300000;
    // The result side holds off for this many cycles during the pressure test.
    localparam int HOLD_CYCLES = 150;
    // A result is offered in the cycle after byte 8 moves, so a short wait at
    // the end is enough to catch any result that was not asked for.
    localparam int DRAIN_SLACK = 20;
    localparam int PRINT_LIMIT = 40;

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_ready;
    logic [7:0]         byte_value;
    logic               frame_start;
    logic               result_valid;
    logic               result_ready;
    logic signed [15:0] temperature_sixteenths;
    logic signed [11:0] whole_degrees;
    logic [3:0]         fraction_sixteenths;
    logic signed [7:0]  high_alarm;
    logic signed [7:0]  low_alarm;
    logic [7:0]         config_byte;
    logic [1:0]         resolution_index;
    logic               crc_ok;
    logic [7:0]         computed_crc;

    // Decoder state kept by the testbench; it mirrors the block after reset.
    logic [3:0]  pad_position = POS_TEMP_LOW;
    logic [7:0]  crc_running  = '0;
    logic [7:0]  temp_low     = '0;
    logic [7:0]  temp_high    = '0;
    logic [7:0]  alarm_high   = '0;
    logic [7:0]  alarm_low    = '0;
    logic [7:0]  config_held  = '0;

    // Decoded frames whose result transfer has not yet been seen.
    ssc_result_t frames_pending[$];

    // Scratchpad image that the frame tasks send.
    logic [7:0]  pad_bytes [0:8];

    int  bytes_decoded  = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  hold_requests  = 0;
    bit  idling_on      = 1'b1;

    sensor_scratchpad_checker uut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .byte_valid             (byte_valid),
        .byte_ready             (byte_ready),
        .byte_value             (byte_value),
        .frame_start            (frame_start),
        .result_valid           (result_valid),
        .result_ready           (result_ready),
        .temperature_sixteenths (temperature_sixteenths),
        .whole_degrees          (whole_degrees),
        .fraction_sixteenths    (fraction_sixteenths),
        .high_alarm             (high_alarm),
        .low_alarm              (low_alarm),
        .config_byte            (config_byte),
        .resolution_index       (resolution_index),
        .crc_ok                 (crc_ok),
        .computed_crc           (computed_crc)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One byte step of the reflected CRC-8, shifting out the low bit first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        int         k;
        c = crc ^ b;
        for (k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
        return c;
    endfunction

    // Advances the decoder by one transferred byte. When byte 8 completes a
    // frame, the decoded result is queued. Returns 0 for a byte that the block
    // drops because it sits idle after a finished frame.
    function automatic bit decode_scratchpad_byte(input logic [7:0] b, input logic start);
        ssc_result_t frame;
        logic [15:0] raw;
        logic [15:0] drop;
        logic [15:0] kept;
        logic [1:0]  res;
        if (start)
        begin
            pad_position = POS_TEMP_LOW;
            crc_running  = '0;
        end
        if (pad_position >= POS_IDLE)
            return 1'b0;
        if (pad_position < CRC_SPAN && pad_position < POS_LAST)
            crc_running = crc8_step(crc_running, b);
        case (pad_position)
            POS_TEMP_LOW:   temp_low    = b;
            POS_TEMP_HIGH:  temp_high   = b;
            POS_ALARM_HIGH: alarm_high  = b;
            POS_ALARM_LOW:  alarm_low   = b;
            POS_CONFIG:     config_held = b;
            default:        ;
        endcase
        if (pad_position < POS_LAST)
        begin
            pad_position = pad_position + 4'd1;
            return 1'b1;
        end
        raw  = {temp_high, temp_low};
        res  = 2'((config_held & RES_FIELD_MASK) >> RES_FIELD_SHIFT);
        drop = 16'((1 << (3 - int'(res))) - 1);
        kept = raw & ~drop;
        frame.temperature_sixteenths = kept;
        frame.whole_degrees          = raw[15:4];
        frame.fraction_sixteenths    = kept[3:0];
        frame.high_alarm             = alarm_high;
        frame.low_alarm              = alarm_low;
        frame.config_byte            = config_held;
        frame.resolution_index       = res;
        frame.crc_ok                 = (crc_running == b);
        frame.computed_crc           = crc_running;
        frames_pending.push_back(frame);
        pad_position = POS_IDLE;
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] seen,
                                 input logic [15:0] wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, wanted));
    endtask

    // Offers one byte at the falling edge and holds it until the transfer
    // happens at a rising edge, then updates the decoder.
    task automatic send_byte(input logic [7:0] value, input logic start);
        int gap;
        gap = (idling_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid  <= 1'b1;
        byte_value  <= value;
        frame_start <= start;
        @(posedge clk);
        while (byte_ready !== 1'b1)
            @(posedge clk);
        if (decode_scratchpad_byte(value, start))
            bytes_decoded++;
    endtask

    // Sends the first count bytes of the scratchpad image; byte 0 carries the
    // given start flag and the rest carry none.
    task automatic send_pad(input int count, input logic first_start);
        int i;
        for (i = 0; i < count; i++)
            send_byte(pad_bytes[i], (i == 0) ? first_start : 1'b0);
    endtask

    // Writes the CRC byte of the image, either correct or spoilt.
    task automatic seal_pad(input bit good);
        logic [7:0] crc;
        int         i;
        crc = '0;
        for (i = 0; i < 8; i++)
            if (i < CRC_SPAN)
                crc = crc8_step(crc, pad_bytes[i]);
        pad_bytes[8] = good ? crc : crc ^ 8'($urandom_range(1, 255));
    endtask

    task automatic fill_random_pad();
        int i;
        for (i = 0; i < 9; i++)
            pad_bytes[i] = 8'($urandom_range(0, 255));
    endtask

    // The sender stops offering and waits until every decoded frame is back.
    task automatic wait_for_results();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (frames_pending.size() != 0)
            @(posedge clk);
    endtask

    // Straight after reset the position is already zero, so a frame whose
    // first byte carries no start flag must still decode. The bytes sit at
    // the extremes: a negative temperature, the largest and smallest alarms
    // and twelve-bit resolution.
    task automatic test_first_frame_after_reset();
        pad_bytes[0] = 8'hFF;
        pad_bytes[1] = 8'h80;
        pad_bytes[2] = 8'h7F;
        pad_bytes[3] = 8'h80;
        pad_bytes[4] = 8'h7F;
        pad_bytes[5] = 8'hFF;
        pad_bytes[6] = 8'h00;
        pad_bytes[7] = 8'h10;
        seal_pad(1'b1);
        send_pad(9, 1'b0);
        wait_for_results();
    endtask

    // Bytes after a finished frame are dropped, a start flag in the middle of
    // a frame throws the partial frame away, and a bad CRC byte is flagged.
    // The config byte selects nine-bit resolution with its other bits set.
    task automatic test_restart_and_trailing_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        pad_bytes[0] = 8'h55;
        pad_bytes[1] = 8'h01;
        pad_bytes[2] = 8'h19;
        pad_bytes[3] = 8'h0A;
        send_pad(4, 1'b1);
        pad_bytes[0] = 8'hD0;
        pad_bytes[1] = 8'h07;
        pad_bytes[2] = 8'h4B;
        pad_bytes[3] = 8'h46;
        pad_bytes[4] = 8'h9F;
        pad_bytes[5] = 8'hFF;
        pad_bytes[6] = 8'h0C;
        pad_bytes[7] = 8'h10;
        seal_pad(1'b0);
        send_pad(9, 1'b1);
        wait_for_results();
    endtask

    // Frames follow one another with no gap on either side, so byte 0 of a
    // frame transfers in the cycle straight after byte 8 of the one before.
    task automatic test_back_to_back_frames();
        idling_on = 1'b0;
        repeat (12)
        begin
            fill_random_pad();
            seal_pad($urandom_range(0, 3) != 0);
            send_pad(9, 1'b1);
        end
        wait_for_results();
        idling_on = 1'b1;
    endtask

    // The result side holds off for a long stretch while frames keep coming,
    // so the output register fills and the byte channel must stall. The
    // sender then pauses until every result has come out.
    task automatic test_output_backpressure();
        idling_on = 1'b0;
        hold_requests++;
        repeat (4)
        begin
            fill_random_pad();
            seal_pad(1'b1);
            send_pad(9, 1'b1);
        end
        wait_for_results();
        idling_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, the rest truncated
    // frames, stray bytes after a finished frame and plain noise. Idling is
    // switched off now and then for a stretch.
    task automatic test_random_frames();
        int kind;
        while (bytes_decoded < ITEM_TARGET)
        begin
            idling_on = ($urandom_range(0, 7) != 0);
            kind = $urandom_range(0, 9);
            fill_random_pad();
            if (kind <= 6)
            begin
                seal_pad($urandom_range(0, 3) != 0);
                send_pad(9, 1'b1);
            end
            else if (kind == 7)
            begin
                send_pad($urandom_range(1, 8), 1'b1);
            end
            else if (kind == 8)
            begin
                seal_pad(1'b1);
                send_pad(9, 1'b1);
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
        idling_on = 1'b1;
    endtask

    // Drives result_ready. Long holds asked for by a test are counted here in
    // cycles; otherwise random gaps appear while idling is on.
    initial
    begin : result_sink
        int gap_left;
        int hold_left;
        int hold_served;
        gap_left     = 0;
        hold_left    = 0;
        hold_served  = 0;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                result_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // Every result transfer is matched against the oldest decoded frame.
    initial
    begin : result_monitor
        ssc_result_t seen;
        ssc_result_t wanted;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                seen.temperature_sixteenths = temperature_sixteenths;
                seen.whole_degrees          = whole_degrees;
                seen.fraction_sixteenths    = fraction_sixteenths;
                seen.high_alarm             = high_alarm;
                seen.low_alarm              = low_alarm;
                seen.config_byte            = config_byte;
                seen.resolution_index       = resolution_index;
                seen.crc_ok                 = crc_ok;
                seen.computed_crc           = computed_crc;
                if (frames_pending.size() == 0)
                begin
                    report_mismatch("result transfer with no frame outstanding");
                end
                else
                begin
                    wanted = frames_pending.pop_front();
                    compare_field("temperature_sixteenths", seen.temperature_sixteenths,
                                  wanted.temperature_sixteenths);
                    compare_field("whole_degrees", seen.whole_degrees, wanted.whole_degrees);
                    compare_field("fraction_sixteenths", seen.fraction_sixteenths,
                                  wanted.fraction_sixteenths);
                    compare_field("high_alarm", seen.high_alarm, wanted.high_alarm);
                    compare_field("low_alarm", seen.low_alarm, wanted.low_alarm);
                    compare_field("config_byte", seen.config_byte, wanted.config_byte);
                    compare_field("resolution_index", seen.resolution_index,
                                  wanted.resolution_index);
                    compare_field("crc_ok", seen.crc_ok, wanted.crc_ok);
                    compare_field("computed_crc", seen.computed_crc, wanted.computed_crc);
                end
            end
        end
    end

    // A hung handshake ends the run here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       = 1'b0;
        byte_valid  = 1'b0;
        byte_value  = '0;
        frame_start = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_frame_after_reset();
        test_restart_and_trailing_bytes();
        test_back_to_back_frames();
        test_output_backpressure();
        test_random_frames();

        wait_for_results();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
